/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// No dependencies; included by the checker modules only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define CC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cc20_pkg.sv */
// Types and constants of the ChaCha20 byte-stream cipher.
// No dependencies; imported by the cipher core.
`default_nettype none

package cc20_pkg;

    typedef logic [31:0] t_word;

    // The four constant words that open every block state.
    localparam t_word SIGMA [4] = '{32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574};

    // Rotation amounts of the four steps of a quarter round.
    localparam int unsigned ROT_0 = 16;
    localparam int unsigned ROT_1 = 12;
    localparam int unsigned ROT_2 = 8;
    localparam int unsigned ROT_3 = 7;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
    localparam int ROUND_W       = $clog2(ROUNDS);
    localparam int LANES         = 4;
    localparam int BLOCK_WORDS   = 16;
    localparam int POS_W         = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Register indices of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0        = 3'd0,
        CFG_KEY_1        = 3'd1,
        CFG_KEY_2        = 3'd2,
        CFG_KEY_3        = 3'd3,
        CFG_NONCE_LOW    = 3'd4,
        CFG_NONCE_HIGH   = 3'd5,
        CFG_INIT_COUNTER = 3'd6
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } t_state;

    // Left rotation of a word by a fixed amount.
    function automatic t_word rotl32(input t_word v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cc20_if.sv */
// Valid/ready channel interfaces for the input and result items of the cipher.
// No dependencies; used by the cipher top level and its environment.
`default_nettype none

// Input item: one byte and its end-of-message flag.
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       last_byte;

    modport source (output valid, output data_in, output last_byte, input ready);
    modport sink   (input valid, input data_in, input last_byte, output ready);
endinterface

// Result item: the transformed byte and the copied flag.
interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/chacha20_stream_cipher.sv */
// ChaCha20 stream cipher (20 rounds, 32-bit block counter, 96-bit nonce) working on one byte
// per item; depends on cc20_pkg and the channel interfaces in cc20_if.sv. Each item is XORed
// with the next keystream byte and comes out on the result channel with its last flag. While
// a keystream block is held, one item is taken per cycle: the next item is accepted when the
// result register is empty or is being taken in the same cycle. The first item of a message
// and the first item after every 64 bytes start a new block: the block runs on one four-lane
// add-xor-rotate unit, one quarter-round step per cycle, through the 20 rounds and then the
// feed-forward add of the input state, row by row; the result is then loaded from the held
// item, and no new item is accepted until then. Key and nonce are read when a block starts
// and again for the feed-forward add, the initial counter when a message starts.
`default_nettype none

module chacha20_stream_cipher
    import cc20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cc20_in_if.sink               i_byte,
    cc20_out_if.source            o_byte
);

    // Configuration registers.
    t_word r_key [8];
    t_word r_nonce [3];
    t_word r_init_ctr;

    // Control state.
    t_state             r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [1:0]         r_step, n_step;
    logic [1:0]         r_row, n_row;
    t_word              r_ctr, n_ctr;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_blk_rdy, n_blk_rdy;
    logic               r_in_msg, n_in_msg;
    logic               r_out_valid, n_out_valid;

    // Payload state.
    t_word      r_w [BLOCK_WORDS];
    t_word      n_w [BLOCK_WORDS];
    logic [7:0] r_pend_data, n_pend_data;
    logic       r_pend_last, n_pend_last;
    logic [7:0] r_out_data, n_out_data;
    logic       r_out_last, n_out_last;

    // Combinational helpers.
    t_word            v_init [BLOCK_WORDS];
    t_word            v_init_row [LANES];
    t_word            v_x [LANES];
    t_word            v_y [LANES];
    t_word            v_sum [LANES];
    t_word            v_mix [LANES];
    t_word            v_rot [LANES];
    t_word            v_ctr_sel;
    t_word            v_ks_word;
    logic [7:0]       v_ks_byte;
    logic [POS_W-1:0] v_pos_eff;
    logic [POS_W-1:0] v_em_pos;
    logic [POS_W-1:0] v_pos_inc;
    logic [7:0]       v_em_data;
    logic             v_em_last;
    logic             v_out_free;
    logic             v_accept;
    logic             v_start;
    logic             v_rdy_eff;

    assign v_out_free = !r_out_valid || o_byte.ready;
    assign i_byte.ready = (r_state == S_IDLE) && v_out_free;
    assign v_accept = i_byte.valid && i_byte.ready;
    assign v_start = !r_in_msg;
    assign v_rdy_eff = r_in_msg && r_blk_rdy;
    assign v_pos_eff = v_start ? '0 : r_pos;
    assign v_ctr_sel = ((r_state == S_IDLE) && v_start) ? r_init_ctr : r_ctr;

    assign o_byte.valid    = r_out_valid;
    assign o_byte.data_out = r_out_data;
    assign o_byte.last_out = r_out_last;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_key[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_nonce[i] <= '0;
            end
            r_init_ctr <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_0: begin
                    r_key[0] <= i_cfg_data[31:0];
                    r_key[1] <= i_cfg_data[63:32];
                end
                CFG_KEY_1: begin
                    r_key[2] <= i_cfg_data[31:0];
                    r_key[3] <= i_cfg_data[63:32];
                end
                CFG_KEY_2: begin
                    r_key[4] <= i_cfg_data[31:0];
                    r_key[5] <= i_cfg_data[63:32];
                end
                CFG_KEY_3: begin
                    r_key[6] <= i_cfg_data[31:0];
                    r_key[7] <= i_cfg_data[63:32];
                end
                CFG_NONCE_LOW: begin
                    r_nonce[0] <= i_cfg_data[31:0];
                    r_nonce[1] <= i_cfg_data[63:32];
                end
                CFG_NONCE_HIGH: begin
                    r_nonce[2] <= i_cfg_data[31:0];
                end
                CFG_INIT_COUNTER: begin
                    r_init_ctr <= i_cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Initial block state from constants, key, counter and nonce.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            v_init[i]     = SIGMA[i];
            v_init[4 + i] = r_key[i];
            v_init[8 + i] = r_key[4 + i];
        end
        v_init[12] = v_ctr_sel;
        v_init[13] = r_nonce[0];
        v_init[14] = r_nonce[1];
        v_init[15] = r_nonce[2];
    end

    // Row of the initial state that the feed-forward add needs in this cycle.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            unique case (r_row)
                2'd0:    v_init_row[i] = v_init[i];
                2'd1:    v_init_row[i] = v_init[4 + i];
                2'd2:    v_init_row[i] = v_init[8 + i];
                default: v_init_row[i] = v_init[12 + i];
            endcase
        end
    end

    // Shared four-lane add-xor-rotate unit; lane i works on column i of the rows.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (r_state == S_FINAL) begin
                v_x[i] = r_w[i];
                v_y[i] = v_init_row[i];
            end else if (r_step[0]) begin
                v_x[i] = r_w[8 + i];
                v_y[i] = r_w[12 + i];
            end else begin
                v_x[i] = r_w[i];
                v_y[i] = r_w[4 + i];
            end
            v_sum[i] = v_x[i] + v_y[i];
            v_mix[i] = (r_step[0] ? r_w[4 + i] : r_w[12 + i]) ^ v_sum[i];
            case (r_step)
                2'd0:    v_rot[i] = rotl32(v_mix[i], ROT_0);
                2'd1:    v_rot[i] = rotl32(v_mix[i], ROT_1);
                2'd2:    v_rot[i] = rotl32(v_mix[i], ROT_2);
                default: v_rot[i] = rotl32(v_mix[i], ROT_3);
            endcase
        end
    end

    // Keystream byte for the item being emitted.
    always_comb begin
        if (r_state == S_EMIT) begin
            v_em_pos  = r_pos;
            v_em_data = r_pend_data;
            v_em_last = r_pend_last;
        end else begin
            v_em_pos  = v_pos_eff;
            v_em_data = i_byte.data_in;
            v_em_last = i_byte.last_byte;
        end
        v_pos_inc = v_em_pos + 1'b1;
        v_ks_word = r_w[v_em_pos[POS_W-1:2]];
        v_ks_byte = v_ks_word[{v_em_pos[1:0], 3'b000} +: 8];
    end

    // Sequencer: next state, working words and result register.
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_step      = r_step;
        n_row       = r_row;
        n_ctr       = r_ctr;
        n_pos       = r_pos;
        n_blk_rdy   = r_blk_rdy;
        n_in_msg    = r_in_msg;
        n_pend_data = r_pend_data;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid && !o_byte.ready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_w         = r_w;

        unique case (r_state)
            S_IDLE: begin
                if (v_accept) begin
                    n_ctr = v_ctr_sel;
                    if (v_rdy_eff) begin
                        // Block in hand: the result leaves at once.
                        n_out_valid = 1'b1;
                        n_out_data  = v_em_data ^ v_ks_byte;
                        n_out_last  = v_em_last;
                        n_pos       = v_pos_inc;
                        n_blk_rdy   = (v_pos_inc != '0);
                        n_in_msg    = !v_em_last;
                    end else begin
                        // Hold the item and start a fresh block.
                        n_pend_data = i_byte.data_in;
                        n_pend_last = i_byte.last_byte;
                        n_pos       = v_pos_eff;
                        n_blk_rdy   = 1'b0;
                        n_in_msg    = 1'b1;
                        n_w         = v_init;
                        n_round     = '0;
                        n_step      = '0;
                        n_state     = S_ROUND;
                    end
                end
            end

            S_ROUND: begin
                if (!r_step[0]) begin
                    for (int i = 0; i < LANES; i++) begin
                        n_w[i]      = v_sum[i];
                        n_w[12 + i] = v_rot[i];
                    end
                end else if (r_step != 2'd3) begin
                    for (int i = 0; i < LANES; i++) begin
                        n_w[8 + i] = v_sum[i];
                        n_w[4 + i] = v_rot[i];
                    end
                end else if (!r_round[0]) begin
                    // End of a column round: skew the rows so diagonals line up as columns.
                    for (int i = 0; i < LANES; i++) begin
                        n_w[4 + i]  = v_rot[(i + 1) % LANES];
                        n_w[8 + i]  = v_sum[(i + 2) % LANES];
                        n_w[12 + i] = r_w[12 + ((i + 3) % LANES)];
                    end
                end else begin
                    // End of a diagonal round: undo the skew.
                    for (int i = 0; i < LANES; i++) begin
                        n_w[4 + i]  = v_rot[(i + 3) % LANES];
                        n_w[8 + i]  = v_sum[(i + 2) % LANES];
                        n_w[12 + i] = r_w[12 + ((i + 1) % LANES)];
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        n_row   = '0;
                        n_state = S_FINAL;
                    end else begin
                        n_round = r_round + 1'b1;
                    end
                end
            end

            S_FINAL: begin
                // Add the initial state row by row while the rows roll upwards.
                for (int i = 0; i < LANES; i++) begin
                    n_w[i]      = r_w[4 + i];
                    n_w[4 + i]  = r_w[8 + i];
                    n_w[8 + i]  = r_w[12 + i];
                    n_w[12 + i] = v_sum[i];
                end
                n_row = r_row + 1'b1;
                if (r_row == 2'd3) begin
                    n_ctr   = r_ctr + 1'b1;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (v_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = v_em_data ^ v_ks_byte;
                    n_out_last  = v_em_last;
                    n_pos       = v_pos_inc;
                    n_blk_rdy   = (v_pos_inc != '0);
                    n_in_msg    = !v_em_last;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_step      <= '0;
            r_row       <= '0;
            r_ctr       <= '0;
            r_pos       <= '0;
            r_blk_rdy   <= 1'b0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_step      <= n_step;
            r_row       <= n_row;
            r_ctr       <= n_ctr;
            r_pos       <= n_pos;
            r_blk_rdy   <= n_blk_rdy;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_pend_data <= n_pend_data;
        r_pend_last <= n_pend_last;
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
    end

endmodule

`default_nettype wire

/* rtl/core/cc20_checker.sv */
// Port-level checker for the ChaCha20 byte-stream cipher, bound to its top level.
// Depends on assert_macros.svh and on chacha20_stream_cipher for the bind.
`default_nettype none
`include "assert_macros.svh"

module cc20_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    // A result that is not taken stays offered.
    `CC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result item dropped while stalled")

    // A new item is only taken when the result register is free or draining.
    `CC_ASSERT(a_no_overrun, i_clk, i_rst_n, i_in_ready && i_out_valid |-> i_out_ready, "item accepted while result blocked")

    // An accepted item either yields a result at once or closes the input while a block runs.
    `CC_ASSERT(a_accept_progress, i_clk, i_rst_n, i_in_valid && i_in_ready |=> i_out_valid || !i_in_ready, "accepted item neither emitted nor held")

    // Reset empties the result register.
    `CC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result item offered after reset")

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready)
);

`default_nettype wire
